// ===== sv/swept_oriented_box_bounds_top_defines.svh =====
// assertion macros for the swept box bounds block
// used by the top level; expects clk_i and rst_ni in scope
`ifndef SWEPT_ORIENTED_BOX_BOUNDS_TOP_DEFINES_SVH
`define SWEPT_ORIENTED_BOX_BOUNDS_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define SOBB_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error("sobb check failed");

// condition implies consequence in the next cycle
`define SOBB_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("sobb check failed");

`endif

// ===== sv/sobb_pkg.sv =====
// constants shared by the swept box bounds block and its channel interfaces
// no dependencies
`timescale 1ns / 1ps

package sobb_pkg;

  // integer bits of an axis component
  localparam int AXIS_INT = 2;
  // output extents are this many bits wider than a component
  localparam int EXT_GROW = 2;
  // magnitudes feeding the length are brought below 2^NORM_BITS
  localparam int NORM_BITS = 30;
  // square root steps for a sum of three squares
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_BITS = 2 * SQRT_STEPS - 1;

endpackage

// ===== sv/sobb_if.sv =====
// valid/ready channel interfaces for the swept box bounds block
// depends on sobb_pkg
`timescale 1ns / 1ps

interface sobb_in_if #(
  parameter int W = 16
);
  logic           valid;
  logic           ready;
  logic [3*W-1:0] half_extents;
  logic [3*W-1:0] box_center;
  logic [3*W-1:0] rot_col0;
  logic [3*W-1:0] rot_col1;
  logic [3*W-1:0] rot_col2;
  logic [3*W-1:0] sweep_dir;
  logic [W-1:0]   sweep_length;

  modport source (
    output valid, half_extents, box_center, rot_col0, rot_col1, rot_col2,
           sweep_dir, sweep_length,
    input  ready
  );
  modport sink (
    input  valid, half_extents, box_center, rot_col0, rot_col1, rot_col2,
           sweep_dir, sweep_length,
    output ready
  );
endinterface

interface sobb_out_if #(
  parameter int W = 16
);
  logic                                 valid;
  logic                                 ready;
  logic [3*W-1:0]                       out_center;
  logic [3*(W+sobb_pkg::EXT_GROW)-1:0]  out_extents;
  logic [3*W-1:0]                       out_axis0;
  logic [3*W-1:0]                       out_axis1;
  logic [3*W-1:0]                       out_axis2;
  logic                                 degenerate;

  modport source (
    output valid, out_center, out_extents, out_axis0, out_axis1, out_axis2,
           degenerate,
    input  ready
  );
  modport sink (
    input  valid, out_center, out_extents, out_axis0, out_axis1, out_axis2,
           degenerate,
    output ready
  );
endinterface

// ===== sv/swept_oriented_box_bounds_top.sv =====
// swept oriented box bounds, fully pipelined
// depends on sobb_pkg, sobb_if and swept_oriented_box_bounds_top_defines.svh
//
//   channel   role     handshake      payload
//   in_i      sink     valid/ready    box, rotation, sweep direction and length
//   out_o     source   valid/ready    swept box center, extents, axes, flag
//
// one item per cycle while the output is not stalled
// the pipeline includes the 32-stage square root and the COMPONENT_WIDTH-1 stage divider
// reset clears only the stage valid bits
// a stalled output freezes every stage; in_i.ready is low only then
`timescale 1ns / 1ps
`include "swept_oriented_box_bounds_top_defines.svh"

module swept_oriented_box_bounds_top #(
  parameter int COMPONENT_WIDTH = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  sobb_in_if.sink   in_i,
  sobb_out_if.source out_o
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int AF  = W - sobb_pkg::AXIS_INT;
  localparam int EW  = W + sobb_pkg::EXT_GROW;
  localparam int DW  = 2 * W + 1;
  localparam int RW  = W + 4;
  localparam int PW  = 2 * W + 5;
  localparam int NB  = sobb_pkg::NORM_BITS;
  localparam int SB  = sobb_pkg::SQRT_BITS;
  localparam int LW  = sobb_pkg::SQRT_STEPS - 1;
  localparam int QB  = AF + 1;
  localparam int NW  = LW + AF;
  localparam int XW  = 2 * W + 10;

  localparam int SQ0 = 8;
  localparam int SQE = SQ0 + sobb_pkg::SQRT_STEPS;
  localparam int DV0 = SQE + 1;
  localparam int AXS = DV0 + QB;
  localparam int X1  = AXS + 1;
  localparam int X2  = AXS + 2;
  localparam int E1  = AXS + 3;
  localparam int E2  = AXS + 4;
  localparam int E3  = AXS + 5;
  localparam int E4  = AXS + 6;
  localparam int E5  = AXS + 7;
  localparam int NST = E5 + 1;

  typedef logic signed [XW-1:0] xs_t;

  typedef struct {
    logic        [W-1:0]     ext [3];
    logic signed [W-1:0]     ctr [3];
    logic signed [W-1:0]     col [3][3];
    logic signed [W-1:0]     dir [3];
    logic        [W-1:0]     slen;
    logic signed [2*W:0]     cp [3];
    logic signed [2*W-1:0]   pr [9];
    logic signed [DW-1:0]    dd [3];
    logic        [RW-1:0]    rd0 [3];
    logic signed [W-1:0]     sel [3];
    logic signed [RW-1:0]    dr;
    logic signed [PW-1:0]    mp [3];
    logic signed [PW-1:0]    p [3];
    logic        [PW-1:0]    mag;
    logic        [NB-1:0]    q [3];
    logic        [2*NB-1:0]  sq [3];
    logic        [SB-1:0]    sv;
    logic        [SB-1:0]    sr;
    logic        [LW-1:0]    len;
    logic        [NW-1:0]    dn [3];
    logic        [QB-1:0]    quo [3];
    logic                    degen;
    logic signed [W-1:0]     ax1 [3];
    logic signed [W-1:0]     ax2 [3];
    logic signed [2*W-1:0]   xp [6];
    logic signed [2*W-1:0]   ep [24];
    logic        [RW-1:0]    rc [2][3];
    logic signed [RW-1:0]    rdir [2];
    logic        [RW+W-1:0]  tp [3][3];
    logic signed [RW+W:0]    op [2];
    xs_t                     acc [3];
    logic        [EW-1:0]    oe [3];
  } stage_t;

  stage_t           pipe_d [NST];
  stage_t           pipe_q [NST];
  logic [NST-1:0]   vld_q;
  logic             en;

  function automatic xs_t rnd(input xs_t x, input int s);
    return (x + (xs_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic xs_t absx(input xs_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic signed [W-1:0] sat_s(input xs_t x);
    if (x > ((xs_t'(1) <<< (W - 1)) - xs_t'(1))) begin
      return {1'b0, {(W-1){1'b1}}};
    end else if (x < -(xs_t'(1) <<< (W - 1))) begin
      return {1'b1, {(W-1){1'b0}}};
    end
    return x[W-1:0];
  endfunction

  assign en         = !vld_q[NST-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    xs_t              ab [3];
    xs_t              dmax;
    xs_t              tv;
    logic [1:0]       a0;
    logic [1:0]       a1;
    logic [1:0]       tsw;
    logic [PW-1:0]    pa [3];
    int               kv;
    int               jb;
    logic [SB-1:0]    bitv;
    logic [SB-1:0]    sumv;
    logic [NW-1:0]    shv;

    // input capture and first products
    pipe_d[0] = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      pipe_d[0].ext[i]    = in_i.half_extents[i*W +: W];
      pipe_d[0].ctr[i]    = $signed(in_i.box_center[i*W +: W]);
      pipe_d[0].col[0][i] = $signed(in_i.rot_col0[i*W +: W]);
      pipe_d[0].col[1][i] = $signed(in_i.rot_col1[i*W +: W]);
      pipe_d[0].col[2][i] = $signed(in_i.rot_col2[i*W +: W]);
      pipe_d[0].dir[i]    = $signed(in_i.sweep_dir[i*W +: W]);
    end
    pipe_d[0].slen = in_i.sweep_length;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        pipe_d[0].pr[3*c+j] = pipe_d[0].col[c][j] * pipe_d[0].dir[j];
      end
      pipe_d[0].cp[c] = pipe_d[0].dir[c] * $signed({1'b0, in_i.sweep_length});
    end

    for (int s = 1; s < NST; s++) begin
      pipe_d[s] = pipe_q[s-1];
    end

    // dots with the direction, moved center
    for (int c = 0; c < 3; c++) begin
      pipe_d[1].dd[c] = DW'(xs_t'(pipe_d[1].pr[3*c]) + xs_t'(pipe_d[1].pr[3*c+1])
                            + xs_t'(pipe_d[1].pr[3*c+2]));
      pipe_d[1].ctr[c] = sat_s(xs_t'(pipe_d[1].ctr[c]) + rnd(xs_t'(pipe_d[1].cp[c]), AF + 1));
    end

    // least aligned column
    for (int c = 0; c < 3; c++) begin
      ab[c] = absx(xs_t'(pipe_d[2].dd[c]));
      pipe_d[2].rd0[c] = RW'(absx(rnd(xs_t'(pipe_d[2].dd[c]), AF)));
    end
    dmax = ab[0];
    a0   = 2'd1;
    a1   = 2'd2;
    tsw  = 2'd0;
    if (ab[1] > dmax) begin
      dmax = ab[1];
      a0   = 2'd0;
      a1   = 2'd2;
    end
    if (ab[2] > dmax) begin
      a0 = 2'd0;
      a1 = 2'd1;
    end
    if (ab[a1] < ab[a0]) begin
      tsw = a0;
      a0  = a1;
      a1  = tsw;
    end
    for (int j = 0; j < 3; j++) begin
      pipe_d[2].sel[j] = pipe_d[2].col[a0][j];
    end
    pipe_d[2].dr = RW'(rnd(xs_t'(pipe_d[2].dd[a0]), AF));

    // projection
    for (int j = 0; j < 3; j++) begin
      pipe_d[3].mp[j] = pipe_d[3].dr * pipe_d[3].dir[j];
    end
    pipe_d[4].mag = '0;
    for (int j = 0; j < 3; j++) begin
      pipe_d[4].p[j] = PW'((xs_t'(pipe_d[4].sel[j]) <<< AF) - xs_t'(pipe_d[4].mp[j]));
      pa[j] = PW'(absx(xs_t'(pipe_d[4].p[j])));
      if (pa[j] > pipe_d[4].mag) begin
        pipe_d[4].mag = pa[j];
      end
    end

    // bring magnitudes into range for the length
    kv = 0;
    for (int b = NB; b < PW; b++) begin
      if (pipe_d[5].mag[b]) begin
        kv = b - NB + 1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      pa[j] = PW'(absx(xs_t'(pipe_d[5].p[j])));
      pipe_d[5].q[j] = NB'(pa[j] >> kv);
    end

    for (int j = 0; j < 3; j++) begin
      pipe_d[6].sq[j] = pipe_d[6].q[j] * pipe_d[6].q[j];
    end

    sumv = SB'(pipe_d[7].sq[0]) + SB'(pipe_d[7].sq[1]) + SB'(pipe_d[7].sq[2]);
    pipe_d[7].sv    = sumv;
    pipe_d[7].sr    = '0;
    pipe_d[7].degen = (pipe_d[7].mag == '0);

    // square root, one result bit per stage
    for (int s = 0; s < sobb_pkg::SQRT_STEPS; s++) begin
      bitv = SB'(1) << (SB - 1 - 2 * s);
      if (pipe_d[SQ0+s].sv >= pipe_d[SQ0+s].sr + bitv) begin
        pipe_d[SQ0+s].sv = pipe_d[SQ0+s].sv - (pipe_d[SQ0+s].sr + bitv);
        pipe_d[SQ0+s].sr = (pipe_d[SQ0+s].sr >> 1) + bitv;
      end else begin
        pipe_d[SQ0+s].sr = pipe_d[SQ0+s].sr >> 1;
      end
    end

    pipe_d[SQE].len = pipe_d[SQE].sr[LW-1:0];
    for (int j = 0; j < 3; j++) begin
      pipe_d[SQE].dn[j]  = (NW'(pipe_d[SQE].q[j]) << AF) + NW'(pipe_d[SQE].len >> 1);
      pipe_d[SQE].quo[j] = '0;
    end

    // normalizing divide, one quotient bit per stage
    for (int s = 0; s < QB; s++) begin
      jb  = QB - 1 - s;
      shv = NW'(pipe_d[DV0+s].len) << jb;
      for (int j = 0; j < 3; j++) begin
        if (pipe_d[DV0+s].dn[j] >= shv) begin
          pipe_d[DV0+s].dn[j]      = pipe_d[DV0+s].dn[j] - shv;
          pipe_d[DV0+s].quo[j][jb] = 1'b1;
        end
      end
    end

    for (int j = 0; j < 3; j++) begin
      if (pipe_d[AXS].degen) begin
        pipe_d[AXS].ax1[j] = '0;
      end else if (pipe_d[AXS].p[j] < 0) begin
        pipe_d[AXS].ax1[j] = -$signed({1'b0, pipe_d[AXS].quo[j]});
      end else begin
        pipe_d[AXS].ax1[j] = $signed({1'b0, pipe_d[AXS].quo[j]});
      end
    end

    // third axis
    pipe_d[X1].xp[0] = pipe_d[X1].dir[1] * pipe_d[X1].ax1[2];
    pipe_d[X1].xp[1] = pipe_d[X1].dir[2] * pipe_d[X1].ax1[1];
    pipe_d[X1].xp[2] = pipe_d[X1].dir[2] * pipe_d[X1].ax1[0];
    pipe_d[X1].xp[3] = pipe_d[X1].dir[0] * pipe_d[X1].ax1[2];
    pipe_d[X1].xp[4] = pipe_d[X1].dir[0] * pipe_d[X1].ax1[1];
    pipe_d[X1].xp[5] = pipe_d[X1].dir[1] * pipe_d[X1].ax1[0];
    for (int j = 0; j < 3; j++) begin
      tv = xs_t'(pipe_d[X2].xp[2*j]) - xs_t'(pipe_d[X2].xp[2*j+1]);
      pipe_d[X2].ax2[j] = sat_s(rnd(tv, AF));
    end

    // extents
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        pipe_d[E1].ep[3*c+j]   = pipe_d[E1].col[c][j] * pipe_d[E1].ax1[j];
        pipe_d[E1].ep[9+3*c+j] = pipe_d[E1].col[c][j] * pipe_d[E1].ax2[j];
      end
      pipe_d[E1].ep[18+c] = pipe_d[E1].dir[c] * pipe_d[E1].ax1[c];
      pipe_d[E1].ep[21+c] = pipe_d[E1].dir[c] * pipe_d[E1].ax2[c];
    end
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 3; c++) begin
        tv = xs_t'(pipe_d[E2].ep[9*r+3*c]) + xs_t'(pipe_d[E2].ep[9*r+3*c+1])
             + xs_t'(pipe_d[E2].ep[9*r+3*c+2]);
        pipe_d[E2].rc[r][c] = RW'(absx(rnd(tv, AF)));
      end
      tv = xs_t'(pipe_d[E2].ep[18+3*r]) + xs_t'(pipe_d[E2].ep[19+3*r])
           + xs_t'(pipe_d[E2].ep[20+3*r]);
      pipe_d[E2].rdir[r] = RW'(rnd(tv, AF));
    end
    for (int c = 0; c < 3; c++) begin
      pipe_d[E3].tp[0][c] = pipe_d[E3].rd0[c] * pipe_d[E3].ext[c];
      pipe_d[E3].tp[1][c] = pipe_d[E3].rc[0][c] * pipe_d[E3].ext[c];
      pipe_d[E3].tp[2][c] = pipe_d[E3].rc[1][c] * pipe_d[E3].ext[c];
    end
    for (int r = 0; r < 2; r++) begin
      pipe_d[E3].op[r] = $signed({1'b0, pipe_d[E3].slen}) * pipe_d[E3].rdir[r];
    end
    for (int r = 0; r < 3; r++) begin
      tv = xs_t'(pipe_d[E4].tp[r][0]) + xs_t'(pipe_d[E4].tp[r][1])
           + xs_t'(pipe_d[E4].tp[r][2]);
      if (r == 0) begin
        pipe_d[E4].acc[r] = (xs_t'(pipe_d[E4].slen) <<< AF) + (tv <<< 1);
      end else begin
        pipe_d[E4].acc[r] = xs_t'(pipe_d[E4].op[r-1]) + (tv <<< 1);
      end
    end
    for (int r = 0; r < 3; r++) begin
      tv = rnd(pipe_d[E5].acc[r], AF + 1);
      if (tv < 0) begin
        pipe_d[E5].oe[r] = '0;
      end else if (tv > ((xs_t'(1) <<< EW) - xs_t'(1))) begin
        pipe_d[E5].oe[r] = '1;
      end else begin
        pipe_d[E5].oe[r] = tv[EW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
    end
  end

  assign out_o.valid       = vld_q[NST-1];
  assign out_o.out_center  = {pipe_q[NST-1].ctr[2], pipe_q[NST-1].ctr[1],
                              pipe_q[NST-1].ctr[0]};
  assign out_o.out_extents = {pipe_q[NST-1].oe[2], pipe_q[NST-1].oe[1],
                              pipe_q[NST-1].oe[0]};
  assign out_o.out_axis0   = {pipe_q[NST-1].dir[2], pipe_q[NST-1].dir[1],
                              pipe_q[NST-1].dir[0]};
  assign out_o.out_axis1   = {pipe_q[NST-1].ax1[2], pipe_q[NST-1].ax1[1],
                              pipe_q[NST-1].ax1[0]};
  assign out_o.out_axis2   = {pipe_q[NST-1].ax2[2], pipe_q[NST-1].ax2[1],
                              pipe_q[NST-1].ax2[0]};
  assign out_o.degenerate  = pipe_q[NST-1].degen;

  `SOBB_ASSERT_NEXT(a_accept_enters, in_i.valid && in_i.ready, vld_q[0])
  `SOBB_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld_q))
  `SOBB_ASSERT_NOW(a_degen_zero_axes, out_o.valid && out_o.degenerate, (out_o.out_axis1 == '0) && (out_o.out_axis2 == '0))
  `SOBB_ASSERT_NOW(a_len_nonzero, vld_q[SQE] && !pipe_q[SQE].degen, pipe_q[SQE].len != '0)

endmodule

// ===== tb/sobb_checker.sv =====
// checker for the swept oriented box bounds block: predicts each result from the accepted
// input items and compares it with the output channel; depends on sobb_pkg and sobb_if
`timescale 1ns / 1ps

module sobb_checker #(
  parameter int W = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sobb_in_if          in_i,
  sobb_out_if         out_o,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          degen_seen_o
);
  localparam int AF = W - 2;
  localparam int EW = W + sobb_pkg::EXT_GROW;

  typedef struct packed {
    logic [3*W-1:0]  center;
    logic [3*EW-1:0] extents;
    logic [3*W-1:0]  axis0;
    logic [3*W-1:0]  axis1;
    logic [3*W-1:0]  axis2;
    logic            degen;
  } swept_box_t;

  swept_box_t expected_boxes[$];
  int fails;
  int results;
  int degens;

  function automatic longint sfield(logic [3*W-1:0] v, int i);
    logic signed [W-1:0] c;
    c = v[i*W +: W];
    return longint'(c);
  endfunction

  function automatic longint ufield(logic [3*W-1:0] v, int i);
    logic [W-1:0] c;
    c = v[i*W +: W];
    return longint'(c);
  endfunction

  function automatic longint rnd(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint x);
    longint hi;
    hi = (longint'(1) << (W - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint dot(longint a[3], longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic swept_box_t predict_box();
    longint ext[3], ctr[3], col[3][3], dir[3], ax1[3], ax2[3], p[3], q[3];
    longint dd[3], acc, dr, pmax, dmax, sweep_len, v;
    longint ax[3];
    longint unsigned sum, len;
    int a0, a1, t, k;
    swept_box_t b;
    sweep_len = longint'(in_i.sweep_length);
    for (int i = 0; i < 3; i++) begin
      ext[i] = ufield(in_i.half_extents, i);
      ctr[i] = sfield(in_i.box_center, i);
      col[0][i] = sfield(in_i.rot_col0, i);
      col[1][i] = sfield(in_i.rot_col1, i);
      col[2][i] = sfield(in_i.rot_col2, i);
      dir[i] = sfield(in_i.sweep_dir, i);
    end
    for (int i = 0; i < 3; i++) dd[i] = mag(dot(col[i], dir));
    dmax = dd[0];
    a0 = 1;
    a1 = 2;
    if (dd[1] > dmax) begin
      dmax = dd[1];
      a0 = 0;
      a1 = 2;
    end
    if (dd[2] > dmax) begin
      a0 = 0;
      a1 = 1;
    end
    if (dd[a1] < dd[a0]) begin
      t = a0;
      a0 = a1;
      a1 = t;
    end
    dr = rnd(dot(col[a0], dir), AF);
    pmax = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = col[a0][i] * (longint'(1) << AF) - dr * dir[i];
      if (mag(p[i]) > pmax) pmax = mag(p[i]);
    end
    b.degen = (pmax == 0);
    if (b.degen) begin
      for (int i = 0; i < 3; i++) ax1[i] = 0;
    end else begin
      k = 0;
      while ((pmax >> k) >= (longint'(1) << sobb_pkg::NORM_BITS)) k++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        q[i] = mag(p[i]) >> k;
        sum += longint'(q[i] * q[i]);
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
        v = longint'(((unsigned'(q[i]) << AF) + len / 2) / len);
        if (p[i] < 0) v = -v;
        ax1[i] = sat(v);
      end
    end
    ax2[0] = sat(rnd(dir[1] * ax1[2] - dir[2] * ax1[1], AF));
    ax2[1] = sat(rnd(dir[2] * ax1[0] - dir[0] * ax1[2], AF));
    ax2[2] = sat(rnd(dir[0] * ax1[1] - dir[1] * ax1[0], AF));
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) ax[i] = r == 0 ? dir[i] : (r == 1 ? ax1[i] : ax2[i]);
      if (r == 0) acc = sweep_len * (longint'(1) << AF);
      else acc = sweep_len * rnd(dot(dir, ax), AF);
      for (int i = 0; i < 3; i++) acc += 2 * mag(rnd(dot(col[i], ax), AF)) * ext[i];
      acc = rnd(acc, AF + 1);
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << EW) - 1) acc = (longint'(1) << EW) - 1;
      b.extents[r*EW +: EW] = acc[EW-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      v = sat(ctr[i] + rnd(dir[i] * sweep_len, AF + 1));
      b.center[i*W +: W] = v[W-1:0];
      b.axis1[i*W +: W] = ax1[i][W-1:0];
      b.axis2[i*W +: W] = ax2[i][W-1:0];
    end
    b.axis0 = in_i.sweep_dir;
    return b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    swept_box_t want, got;
    if (!rst_ni) begin
      fails <= 0;
      results <= 0;
      degens <= 0;
    end else begin
      if (in_i.valid && in_i.ready) expected_boxes.push_back(predict_box());
      if (out_o.valid && out_o.ready) begin
        got = '{out_o.out_center, out_o.out_extents, out_o.out_axis0,
                out_o.out_axis1, out_o.out_axis2, out_o.degenerate};
        results <= results + 1;
        if (got.degen) degens <= degens + 1;
        if (expected_boxes.size() == 0) begin
          if (fails < 10) $display("unexpected result %h", got);
          fails <= fails + 1;
        end else begin
          want = expected_boxes.pop_front();
          if (want !== got) begin
            if (fails < 10) begin
              $display("mismatch center exp %h got %h", want.center, got.center);
              $display("  extents exp %h got %h", want.extents, got.extents);
              $display("  axis0 exp %h got %h", want.axis0, got.axis0);
              $display("  axis1 exp %h got %h", want.axis1, got.axis1);
              $display("  axis2 exp %h got %h", want.axis2, got.axis2);
              $display("  degenerate exp %b got %b", want.degen, got.degen);
            end
            fails <= fails + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o = expected_boxes.size();
  assign results_o = results;
  assign degen_seen_o = degens;
endmodule

// ===== tb/tb_swept_oriented_box_bounds_top.sv =====
// testbench top for the swept oriented box bounds block: drives directed and random boxes,
// applies output back-pressure and gives the verdict; depends on sobb_pkg, sobb_if, sobb_checker
`timescale 1ns / 1ps

module tb_swept_oriented_box_bounds_top;
  localparam int W = 16;
  localparam int LATENCY = 48 + W;
  localparam int WATCHDOG = 20000;
  localparam logic [W-1:0] ONE = 16'h4000;
  localparam logic [W-1:0] NEG_ONE = 16'hc000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count, pending, results, degen_seen;
  int idle_cycles = 0;
  bit quiet_mode;
  bit hold_off;
  bit sink_done;

  sobb_in_if #(.W(W)) in_ch ();
  sobb_out_if #(.W(W)) out_ch ();

  swept_oriented_box_bounds_top #(.COMPONENT_WIDTH(W)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  sobb_checker #(.W(W)) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .degen_seen_o(degen_seen)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [3*W-1:0] vec(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [W-1:0] axis_comp();
    case ($urandom_range(0, 5))
      0: return ONE;
      1: return NEG_ONE;
      2: return '0;
      3: return W'($urandom_range(0, 32767));
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-1:0] len_comp();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      default: return W'($urandom_range(0, 4095));
    endcase
  endfunction

  // send one item, holding valid until accepted
  task automatic send_box(logic [3*W-1:0] e, logic [3*W-1:0] c, logic [3*W-1:0] r0,
                          logic [3*W-1:0] r1, logic [3*W-1:0] r2, logic [3*W-1:0] d,
                          logic [W-1:0] l);
    while (!quiet_mode && $urandom_range(0, 99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.half_extents <= e;
    in_ch.box_center <= c;
    in_ch.rot_col0 <= r0;
    in_ch.rot_col1 <= r1;
    in_ch.rot_col2 <= r2;
    in_ch.sweep_dir <= d;
    in_ch.sweep_length <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_random(bit well_formed);
    logic [3*W-1:0] r[3];
    logic [3*W-1:0] d;
    int perm;
    if (well_formed) begin
      // signed permutation of the identity, with a direction along a column, a fixed diagonal or random
      r[0] = vec($urandom_range(0, 1) ? ONE : NEG_ONE, '0, '0);
      r[1] = vec('0, $urandom_range(0, 1) ? ONE : NEG_ONE, '0);
      r[2] = vec('0, '0, $urandom_range(0, 1) ? ONE : NEG_ONE);
      perm = $urandom_range(0, 2);
      {r[0], r[perm]} = {r[perm], r[0]};
      case ($urandom_range(0, 2))
        0: d = r[$urandom_range(0, 2)];
        1: d = vec(16'h2d41, 16'h2d41, '0);
        default: d = vec(axis_comp(), axis_comp(), axis_comp());
      endcase
    end else begin
      r[0] = vec(axis_comp(), axis_comp(), axis_comp());
      r[1] = vec(axis_comp(), axis_comp(), axis_comp());
      r[2] = vec(axis_comp(), axis_comp(), axis_comp());
      d = vec(axis_comp(), axis_comp(), axis_comp());
    end
    send_box(vec(len_comp(), len_comp(), len_comp()),
             vec(W'($urandom), W'($urandom), W'($urandom)),
             r[0], r[1], r[2], d, len_comp());
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_ch.ready <= 1'b0;
    else if (quiet_mode || sink_done) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [3*W-1:0] id0, id1, id2;
    in_ch.valid = 1'b0;
    in_ch.half_extents = '0;
    in_ch.box_center = '0;
    in_ch.rot_col0 = '0;
    in_ch.rot_col1 = '0;
    in_ch.rot_col2 = '0;
    in_ch.sweep_dir = '0;
    in_ch.sweep_length = '0;
    id0 = vec(ONE, '0, '0);
    id1 = vec('0, ONE, '0);
    id2 = vec('0, '0, ONE);
    quiet_mode = 1'b0;
    hold_off = 1'b0;
    sink_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity box, axis sweeps, extremes, degenerate columns
    send_box(vec(16'h0100, 16'h0100, 16'h0100), '0, id0, id1, id2, id0, 16'h0100);
    send_box(vec(16'h0100, 16'h0200, 16'h0300), '0, id0, id1, id2, id1, 16'h0400);
    send_box(vec(16'h0100, 16'h0200, 16'h0300), '0, id0, id1, id2, id2, 16'h0000);
    send_box('1, '1, id0, id1, id2, vec(NEG_ONE, '0, '0), '1);
    send_box('1, vec(16'h7fff, 16'h7fff, 16'h7fff), id0, id1, id2, id0, '1);
    send_box('1, vec(16'h8000, 16'h8000, 16'h8000), id0, id1, id2, vec(NEG_ONE, '0, '0), '1);
    send_box('0, '0, '0, '0, '0, '0, '0);
    send_box(vec(16'h0100, '0, '0), '0, id0, id0, id0, id0, 16'h0100);
    send_box(vec(16'h0100, 16'h0100, '0), '0, id0, id1, id2, vec(16'h2d41, 16'h2d41, '0),
             16'h0800);
    send_box('1, '1, '1, '1, '1, '1, '1);
    send_box({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}},
             {3{16'h7fff}}, '1);
    send_box({3{16'h7fff}}, '0, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
             {3{16'h7fff}}, 16'h8000);
    send_box(vec(16'h0100, 16'h0100, 16'h0100), '0, id1, id1, id0,
             vec(16'h2d41, '0, 16'h2d41), 16'h0300);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    // sender pauses until every result is back
    while (pending != 0) @(posedge clk_i);

    // receiver holds off while items keep coming, then a quiet burst
    hold_off = 1'b1;
    fork
      begin
        repeat (3 * LATENCY) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (150) send_random($urandom_range(0, 99) < 75);
    join
    quiet_mode = 1'b1;
    repeat (150) send_random($urandom_range(0, 99) < 75);
    quiet_mode = 1'b0;
    repeat (600) send_random($urandom_range(0, 99) < 75);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    sink_done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("checked %0d swept boxes, %0d degenerate, directed extremes and random rotations",
             results, degen_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
